// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the page table mapper RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define FLPTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define FLPTM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/flptm_pkg.sv =====
// Package for the four-level page table mapper: payload types, codes, widths.
// Depends on nothing; imported by flptm_store, four_level_page_table_mapper and the testbench.
`default_nettype none

package flptm_pkg;

    localparam int TABLE_PAGES_DEF   = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int ENTRY_W           = 64;
    localparam int FRAME_W           = 40;

    localparam logic [1:0] MODE_MAP        = 2'd0;
    localparam logic [1:0] MODE_UNMAP      = 2'd1;
    localparam logic [1:0] MODE_UNMAP_FREE = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_MISSING   = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    phys_addr;
        logic [ENTRY_W-1:0] leaf_flags;
    } map_req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            free_valid;
        logic [PA_W-1:0] free_addr;
        logic            tlb_flush;
    } map_rsp_t;

    // Table index for a walk level: PML4, PDPT, PD, PT.
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/flptm_store.sv =====
// Table store: one write port, one read port, registered read data.
// Depends on flptm_pkg for entry width and page geometry.
`default_nettype none

module flptm_store
    import flptm_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [$clog2(TABLE_PAGES)+IDX_W-1:0]    wr_addr,
    input  wire logic [ENTRY_W-1:0]                      wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [$clog2(TABLE_PAGES)+IDX_W-1:0]    rd_addr,
    output logic      [ENTRY_W-1:0]                      rd_data
);

    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_table_mapper.sv =====
// Flow: the root read is launched in the transfer cycle, each level's entry is checked in turn,
// and the result goes to the output buffer; a newly allocated page is cleared, then reread.
// Requests: the block takes no new request until it is done with the current one; the next transfer
// waits until the current result has moved into the output buffer.
// Reset: asynchronous, active low; afterwards the root page is cleared, during which no request
// is taken (configuration writes are taken at any time).
`default_nettype none

// Top level of the four-level page table mapper: walk sequencer, allocator, result buffer.
// Depends on flptm_pkg, flptm_store and assert_macros.svh.
`include "assert_macros.svh"

module four_level_page_table_mapper
    import flptm_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire map_req_t        in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output map_rsp_t             out_data,
    input  wire logic            cfg_wr_en,
    input  wire logic [PA_W-1:0] cfg_wr_data
);

    localparam int PW = $clog2(TABLE_PAGES);
    localparam int AW = PW + IDX_W;
    localparam int NW = $clog2(TABLE_PAGES + 1);

    // Sequencer codes
    localparam logic [2:0] ST_BOOT   = 3'd0;  // clear the root page after reset
    localparam logic [2:0] ST_IDLE   = 3'd1;  // wait for a request
    localparam logic [2:0] ST_READ   = 3'd2;  // issue a read for the current level
    localparam logic [2:0] ST_CHECK  = 3'd3;  // inspect the entry that came back
    localparam logic [2:0] ST_ZERO   = 3'd4;  // clear a freshly allocated page
    localparam logic [2:0] ST_FINISH = 3'd5;  // hand the result to the output buffer

    logic [2:0]       state_reg,   state_next;
    logic [1:0]       lvl_reg,     lvl_next;
    logic [PW-1:0]    page_reg,    page_next;
    logic [NW-1:0]    nfp_reg,     nfp_next;
    logic [IDX_W-1:0] clr_reg,     clr_next;
    logic [PA_W-1:0]  root_reg,    root_next;
    logic             out_valid_reg, out_valid_next;
    map_req_t         req_reg,     req_next;
    map_rsp_t         res_reg,     res_next;
    map_rsp_t         out_data_reg, out_data_next;

    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    // Entry decode: does the returned entry point into the store?
    logic [FRAME_W-1:0] root_frame;
    logic [FRAME_W:0]   frame_diff;
    logic               entry_follow;
    logic [PW-1:0]      child_page;
    logic               store_full;
    logic [ENTRY_W-1:0] table_entry;
    logic [1:0]         lvl_inc;

    flptm_store #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign root_frame = root_reg[PA_W-1:12];
    // Borrow in the top bit marks a frame below the root: not in the store.
    assign frame_diff = {1'b0, mem_rd_data[PA_W-1:12]} - {1'b0, root_frame};
    assign entry_follow = mem_rd_data[0] && !frame_diff[FRAME_W]
                          && (frame_diff[FRAME_W-1:0] < FRAME_W'(TABLE_PAGES));
    assign child_page = frame_diff[PW-1:0];
    assign store_full = (nfp_reg >= NW'(TABLE_PAGES));
    // New table entry: page address masked to bits 51..12, present|writable|user.
    assign table_entry = {12'h000, FRAME_W'(root_frame + FRAME_W'(nfp_reg)), 9'h000, 3'b111};
    assign lvl_inc = lvl_reg + 2'd1;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration: take the write at once; the whole value is kept, bits 51..12 give the root frame.
    assign root_next = cfg_wr_en ? cfg_wr_data : root_reg;

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        page_next      = page_reg;
        nfp_next       = nfp_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = {page_reg, clr_reg};
        mem_wr_data    = '0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = {page_reg, level_index(req_reg.virt_addr, lvl_reg)};

        unique case (state_reg)
            ST_BOOT:
            begin
                // Sweep the root page to zero, one entry per cycle
                mem_wr_en = 1'b1;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = in_data;
                    res_next    = '0;
                    lvl_next    = 2'd0;
                    page_next   = '0;
                    // Launch the root read in the transfer cycle
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = {PW'(0), level_index(in_data.virt_addr, 2'd0)};
                    case (in_data.mode) inside
                        MODE_MAP, MODE_UNMAP, MODE_UNMAP_FREE: state_next = ST_CHECK;
                        default:                               state_next = ST_FINISH;
                    endcase
                end
            end

            ST_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (lvl_reg != 2'd3)
                begin
                    if (entry_follow)
                    begin
                        // Advance a level and read the child entry right away
                        page_next   = child_page;
                        lvl_next    = lvl_inc;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = {child_page, level_index(req_reg.virt_addr, lvl_inc)};
                    end
                    else if (req_reg.mode != MODE_MAP)
                    begin
                        res_next.status = STATUS_MISSING;
                        state_next      = ST_FINISH;
                    end
                    else if (store_full)
                    begin
                        res_next.status = STATUS_EXHAUSTED;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        // Link a fresh page into the parent, then clear it
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = {page_reg, level_index(req_reg.virt_addr, lvl_reg)};
                        mem_wr_data = table_entry;
                        page_next   = nfp_reg[PW-1:0];
                        nfp_next    = nfp_reg + NW'(1);
                        clr_next    = '0;
                        lvl_next    = lvl_inc;
                        state_next  = ST_ZERO;
                    end
                end
                else
                begin
                    // Leaf: write the mapping or clear it; unmap-free also reports the old frame
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = {page_reg, level_index(req_reg.virt_addr, lvl_reg)};
                    if (req_reg.mode == MODE_MAP)
                    begin
                        mem_wr_data = {12'h000, req_reg.phys_addr} | req_reg.leaf_flags;
                    end
                    else if (req_reg.mode == MODE_UNMAP_FREE)
                    begin
                        res_next.free_valid = 1'b1;
                        res_next.free_addr  = {mem_rd_data[PA_W-1:12], 12'h000};
                    end
                    res_next.tlb_flush = 1'b1;
                    state_next         = ST_FINISH;
                end
            end

            ST_ZERO:
            begin
                mem_wr_en = 1'b1;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_READ;
                end
            end

            ST_FINISH:
            begin
                // Hold until the output buffer is free or drains this cycle
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BOOT;
            lvl_reg       <= 2'd0;
            page_reg      <= '0;
            nfp_reg       <= NW'(1);
            clr_reg       <= '0;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            page_reg      <= page_next;
            nfp_reg       <= nfp_next;
            clr_reg       <= clr_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // A write and a read never share a cycle, so no forwarding is needed
    `FLPTM_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, mem_wr_en, !mem_rd_en, "store read and write overlap")
    `FLPTM_ASSERT_IMP(a_alloc_bound, clk, rst_n, 1'b1, nfp_reg <= NW'(TABLE_PAGES), "allocator ran past the store")
    `FLPTM_ASSERT_IMP(a_flush_done, clk, rst_n, out_valid && out_data.tlb_flush, out_data.status == STATUS_DONE, "flush with error status")
    `FLPTM_ASSERT_IMP(a_free_flush, clk, rst_n, out_valid && out_data.free_valid, out_data.tlb_flush, "freed frame without flush")
    `FLPTM_ASSERT_NXT(a_accept_next, clk, rst_n, in_valid && in_ready, (state_reg == ST_CHECK) || (state_reg == ST_FINISH), "bad state after transfer")

endmodule

`default_nettype wire

// ===== dv/four_level_page_table_mapper_test.sv =====
// Self-checking testbench for four_level_page_table_mapper: directed and random map/unmap traffic.
// Depends on flptm_pkg and the four_level_page_table_mapper RTL; reads no files.
`default_nettype none

module four_level_page_table_mapper_test;
    import flptm_pkg::*;

    localparam int          N_PAGES         = TABLE_PAGES_DEF;
    localparam int          TABLE_SLOTS     = N_PAGES * ENTRIES_PER_TABLE;
    localparam logic [63:0] ADDR_MASK       = 64'h000f_ffff_ffff_f000;
    localparam logic [63:0] PTE_TABLE_BITS  = 64'h7;
    localparam logic [1:0]  MODE_IGNORED    = 2'd3;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          WATCHDOG_LIMIT  = 12000;
    localparam int          PRINT_LIMIT     = 40;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    map_req_t        in_data;
    logic            out_valid;
    logic            out_ready;
    map_rsp_t        out_data;
    logic            cfg_wr_en;
    logic [PA_W-1:0] cfg_wr_data;

    // Shadow of the walker: table image, bump allocator and root register.
    logic [63:0]     table_img [TABLE_SLOTS];
    int unsigned     pages_used;
    logic [PA_W-1:0] root_reg;

    // Responses still owed by the block, oldest first.
    map_rsp_t        expected_rsp [$];

    int              mismatch_count;
    int              rsp_count;
    int              sent_total;
    bit              tx_idle;
    bit              no_gap;
    logic            hold_off;

    // Walk pools: set 0 serves the root-at-zero phases, set 1 the relocated root.
    // Few distinct prefixes keep most requests on existing tables.
    logic [8:0]      pool_top  [2][2];
    logic [8:0]      pool_mid  [2][2];
    logic [8:0]      pool_low  [2][2];
    logic [8:0]      pool_leaf [2][4];

    four_level_page_table_mapper u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Walk prediction
    // ------------------------------------------------------------------

    function automatic logic [63:0] root_base();
        return {12'd0, root_reg} & ADDR_MASK;
    endfunction

    // A present entry leads to a store page only when its address lands inside
    // the store relative to the aligned root; anything else counts as absent.
    function automatic bit follow_entry(input logic [63:0] ent, output int unsigned child);
        logic [63:0] off;
        child = 0;
        if (!ent[0])
            return 1'b0;
        off = ((ent & ADDR_MASK) - root_base()) >> 12;
        if (off >= 64'(N_PAGES))
            return 1'b0;
        child = off[31:0];
        return 1'b1;
    endfunction

    // Apply one request to the shadow tables and return the response it owes.
    function automatic map_rsp_t walk_and_update(input map_req_t req);
        map_rsp_t    rsp;
        logic [8:0]  idx [4];
        int unsigned page;
        int unsigned child;
        int unsigned np;
        int unsigned slot;
        rsp = '0;
        if (req.mode == MODE_IGNORED)
            return rsp;
        idx[0] = req.virt_addr[47:39];
        idx[1] = req.virt_addr[38:30];
        idx[2] = req.virt_addr[29:21];
        idx[3] = req.virt_addr[20:12];
        page = 0;
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            slot = page * ENTRIES_PER_TABLE + idx[lvl];
            if (follow_entry(table_img[slot], child))
            begin
                page = child;
                continue;
            end
            if (req.mode != MODE_MAP)
            begin
                rsp.status = STATUS_MISSING;
                return rsp;
            end
            // Out of pages: keep whatever this request already linked in.
            if (pages_used >= N_PAGES)
            begin
                rsp.status = STATUS_EXHAUSTED;
                return rsp;
            end
            np = pages_used;
            pages_used++;
            for (int k = 0; k < ENTRIES_PER_TABLE; k++)
                table_img[np * ENTRIES_PER_TABLE + k] = '0;
            table_img[slot] = ((root_base() + (64'(np) << 12)) & ADDR_MASK) | PTE_TABLE_BITS;
            page = np;
        end
        slot = page * ENTRIES_PER_TABLE + idx[3];
        if (req.mode == MODE_MAP)
        begin
            table_img[slot] = {12'd0, req.phys_addr} | req.leaf_flags;
        end
        else
        begin
            if (req.mode == MODE_UNMAP_FREE)
            begin
                rsp.free_valid = 1'b1;
                rsp.free_addr  = table_img[slot][PA_W-1:0] & ADDR_MASK[PA_W-1:0];
            end
            table_img[slot] = '0;
        end
        rsp.tlb_flush = 1'b1;
        return rsp;
    endfunction

    // True when the walk never follows a pointer into a page that was never
    // allocated; such pages hold undefined data in the block.
    function automatic bit walk_stays_in_store(input map_req_t req);
        logic [8:0]  idx [3];
        int unsigned page;
        int unsigned child;
        if (req.mode == MODE_IGNORED)
            return 1'b1;
        idx[0] = req.virt_addr[47:39];
        idx[1] = req.virt_addr[38:30];
        idx[2] = req.virt_addr[29:21];
        page = 0;
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            if (!follow_entry(table_img[page * ENTRIES_PER_TABLE + idx[lvl]], child))
                return 1'b1;
            if (child >= pages_used)
                return 1'b0;
            page = child;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic map_req_t draw_request(input int set);
        map_req_t    req;
        logic [63:0] r64;
        logic [8:0]  top;
        logic [8:0]  leaf;
        int          kind;
        kind = $urandom_range(0, 99);
        top  = pool_top[set][(set == 0) ? $urandom_range(0, 1) : 0];
        leaf = ($urandom_range(0, 9) < 7) ? pool_leaf[set][$urandom_range(0, 3)]
                                          : 9'($urandom);
        req.virt_addr = {top, pool_mid[set][$urandom_range(0, 1)],
                         pool_low[set][$urandom_range(0, 1)], leaf, 12'($urandom)};
        r64 = {$urandom, $urandom};
        req.phys_addr  = r64[PA_W-1:0];
        req.leaf_flags = {$urandom, $urandom};
        if (kind < 45)
            req.mode = MODE_MAP;
        else if (kind < 65)
            req.mode = MODE_UNMAP;
        else if (kind < 85)
            req.mode = MODE_UNMAP_FREE;
        else if (kind < 95)
        begin
            // Stray unmaps: wholly random addresses, or a known prefix with a
            // random directory index, which mostly find a missing level.
            req.mode = ($urandom_range(0, 1) != 0) ? MODE_UNMAP : MODE_UNMAP_FREE;
            r64 = {$urandom, $urandom};
            if (kind < 91)
                req.virt_addr = r64[VA_W-1:0];
            else
                req.virt_addr[29:21] = r64[8:0];
        end
        else
            req.mode = MODE_IGNORED;
        return req;
    endfunction

    function automatic map_req_t safe_request(input int set);
        map_req_t req;
        for (int tries = 0; tries < 8; tries++)
        begin
            req = draw_request(set);
            if (walk_stays_in_store(req))
                return req;
        end
        req.mode = MODE_IGNORED;
        return req;
    endfunction

    task automatic seed_pools(input int set);
        for (int i = 0; i < 2; i++)
        begin
            pool_top[set][i] = 9'($urandom);
            pool_mid[set][i] = 9'($urandom);
            pool_low[set][i] = 9'($urandom);
        end
        for (int i = 0; i < 4; i++)
            pool_leaf[set][i] = 9'($urandom);
    endtask

    // Offer one request and hold it until the transfer; call at a clock edge.
    task automatic send_req(input map_req_t req);
        int gap;
        sent_total++;
        if (sent_total % 32 == 0)
            tx_idle = ($urandom_range(0, 2) != 0);
        gap = (tx_idle && !no_gap) ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_rsp.push_back(walk_and_update(req));
    endtask

    // Drop valid and wait until every owed response has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the root register with the block idle.
    task automatic write_root(input logic [PA_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        root_reg = value;
    endtask

    task automatic random_traffic(input int set, input int count);
        for (int n = 0; n < count; n++)
        begin
            send_req(safe_request(set));
            // Pause now and then until the block has answered everything.
            if (n % 250 == 249)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch in response %0d, %s: got %h, want %h",
                     rsp_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_response(input map_rsp_t got);
        map_rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            report_mismatch("response with nothing outstanding", 64'(got), 64'd0);
        end
        else
        begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.free_valid !== want.free_valid)
                report_mismatch("free_valid", 64'(got.free_valid), 64'(want.free_valid));
            if (got.free_addr !== want.free_addr)
                report_mismatch("free_addr", 64'(got.free_addr), 64'(want.free_addr));
            if (got.tlb_flush !== want.tlb_flush)
                report_mismatch("tlb_flush", 64'(got.tlb_flush), 64'(want.tlb_flush));
        end
        rsp_count++;
    endtask

    // Result side: per-transfer random stall, stretches without stalls, and
    // the long hold-off requested by the backpressure test.
    initial
    begin : response_sink
        int rx_gap;
        int rx_seen;
        bit rx_idle;
        rx_gap  = 0;
        rx_seen = 0;
        rx_idle = 1'b1;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_response(out_data);
                rx_seen++;
                if (rx_seen % 40 == 0)
                    rx_idle = ($urandom_range(0, 2) != 0);
                rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
            end
            out_ready <= !hold_off && (rx_gap == 0);
        end
    end

    // Count cycles with work pending and no transfer on either side.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (!in_valid && expected_rsp.size() == 0))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without progress", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh walks, leaf extremes, sibling leaves and a second directory.
    task automatic test_map_walk();
        send_req(map_req_t'{MODE_MAP, 48'h0, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_UNMAP_FREE, 48'h0, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_MAP, {VA_W{1'b1}}, {PA_W{1'b1}}, {ENTRY_W{1'b1}}});
        send_req(map_req_t'{MODE_UNMAP_FREE, {VA_W{1'b1}}, 52'h0, 64'h0});
        // Leaf already cleared: frame reported as zero.
        send_req(map_req_t'{MODE_UNMAP_FREE, {VA_W{1'b1}}, {PA_W{1'b1}}, {ENTRY_W{1'b1}}});
        send_req(map_req_t'{MODE_MAP, 48'h0000_0000_1000, 52'h0_0012_3456_7000,
                            64'h8000_0000_0000_0003});
        send_req(map_req_t'{MODE_MAP, 48'h0000_4000_0000, 52'h0_00ab_cdef_0000,
                            64'h0000_0000_0000_0107});
    endtask

    // Missing levels at the top and in the middle, then plain and reporting unmaps.
    task automatic test_unmap_paths();
        send_req(map_req_t'{MODE_UNMAP, 48'haa80_0000_0000, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_UNMAP_FREE, 48'haa80_0000_0000, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_UNMAP_FREE, 48'h0000_0020_0000, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_UNMAP, 48'h0000_0000_1000, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_UNMAP_FREE, 48'h0000_0000_1000, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_UNMAP_FREE, 48'h0000_4000_0000, 52'h0, 64'h0});
    endtask

    task automatic test_unused_mode();
        send_req(map_req_t'{MODE_IGNORED, {VA_W{1'b1}}, {PA_W{1'b1}}, {ENTRY_W{1'b1}}});
        send_req(map_req_t'{MODE_IGNORED, 48'h0, 52'h0, 64'h0});
    endtask

    // Root at the top of the address space: existing pointers fall outside the
    // store, new table addresses wrap at bit 52, and map reallocates in place.
    task automatic test_pointer_outside_store();
        write_root({PA_W{1'b1}});
        send_req(map_req_t'{MODE_UNMAP, 48'h0, 52'h0, 64'h0});
        send_req(map_req_t'{MODE_MAP, 48'h0, {PA_W{1'b1}}, 64'h0});
        send_req(map_req_t'{MODE_UNMAP_FREE, 48'h0, 52'h0, 64'h0});
        write_root('0);
    endtask

    // Stall the result side for a long stretch while requests keep coming,
    // so the block fills up and pushes back on its input.
    task automatic test_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        no_gap = 1'b1;
        for (int n = 0; n < 30; n++)
            send_req(safe_request(0));
        no_gap = 1'b0;
        wait_drained();
    endtask

    // Map fresh regions until the allocator runs dry, then a few more maps
    // and unmaps against the empty allocator.
    task automatic test_table_exhaustion();
        map_req_t    req;
        logic [63:0] r64;
        int          tries;
        tries = 0;
        while (tries < 400 && (pages_used < N_PAGES || tries < 6))
        begin
            if (pages_used >= N_PAGES)
                tries = (tries < 6) ? 6 : tries;
            r64 = {$urandom, $urandom};
            req.mode       = MODE_MAP;
            req.virt_addr  = r64[VA_W-1:0];
            req.phys_addr  = PA_W'({$urandom, $urandom});
            req.leaf_flags = {$urandom, $urandom};
            if (walk_stays_in_store(req))
                send_req(req);
            tries++;
        end
        for (int n = 0; n < 4; n++)
        begin
            r64 = {$urandom, $urandom};
            req.mode       = (n < 2) ? MODE_MAP : MODE_UNMAP_FREE;
            req.virt_addr  = r64[VA_W-1:0];
            req.phys_addr  = PA_W'({$urandom, $urandom});
            req.leaf_flags = {$urandom, $urandom};
            if (walk_stays_in_store(req))
                send_req(req);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : run
        logic [63:0] r64;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        hold_off    <= 1'b0;
        rst_n       <= 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++)
            table_img[i] = '0;
        pages_used     = 1;
        root_reg       = '0;
        mismatch_count = 0;
        rsp_count      = 0;
        sent_total     = 0;
        tx_idle        = 1'b1;
        no_gap         = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_root('0);
        test_map_walk();
        test_unmap_paths();
        test_unused_mode();
        test_pointer_outside_store();

        seed_pools(0);
        random_traffic(0, 680);
        test_backpressure();

        // Relocate the root to an arbitrary, unaligned address.
        r64 = {$urandom, $urandom};
        write_root(r64[PA_W-1:0]);
        seed_pools(1);
        random_traffic(1, 450);

        write_root('0);
        random_traffic(0, 400);
        test_table_exhaustion();
        random_traffic(0, 350);

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/flptm_pkg.sv
hw/rtl/flptm_store.sv
hw/rtl/four_level_page_table_mapper.sv
dv/four_level_page_table_mapper_test.sv
